@@ rtl/core/dclms_pkg.sv @@
// Shared types and constants for the two-colour matrix frame store and scanner.
package dclms_pkg;

  // Panel geometry: COLUMNS columns, HALF_ROWS row pairs (row r pairs with r + HALF_ROWS).
  localparam int unsigned COLUMNS   = 64;
  localparam int unsigned HALF_ROWS = 16;

  // Field widths fixed by the stream format.
  localparam int unsigned COL_W   = 6;
  localparam int unsigned Y_W     = 5;
  localparam int unsigned ROW_W   = 4;
  localparam int unsigned COLOR_W = 2;

  // Each bank holds one half of the frame, addressed as {row, column}.
  localparam int unsigned ADDR_W = ROW_W + COL_W;
  localparam int unsigned DEPTH  = 2 ** ADDR_W;

  // Request kinds carried on the slave-side tuser.
  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_CLEAR = 2'd1,
    FUNC_SCAN  = 2'd2
  } func_e;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CLEAR = 3'b010,
    ST_SCAN  = 3'b100
  } state_e;

  // Write port of the frame store.
  typedef struct packed {
    logic               en;
    logic               both;   // write both banks (clearing pass)
    logic               lower;  // select the lower half bank
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
  } mem_wr_t;

  // Read data: one pixel from each half of the row pair.
  typedef struct packed {
    logic [COLOR_W-1:0] upper;
    logic [COLOR_W-1:0] lower;
  } pix_pair_t;

endpackage

@@ rtl/core/dclms_frame_mem.sv @@
// Frame store: two synchronous banks, upper and lower half of the panel.
// One write port and one shared read address; read data is registered.
module dclms_frame_mem (
  input  logic                          clk_i,
  input  dclms_pkg::mem_wr_t            wr_i,
  input  logic                          rd_en_i,
  input  logic [dclms_pkg::ADDR_W-1:0]  rd_addr_i,
  output dclms_pkg::pix_pair_t          rd_data_o
);

  logic [dclms_pkg::COLOR_W-1:0] upper_mem [dclms_pkg::DEPTH];
  logic [dclms_pkg::COLOR_W-1:0] lower_mem [dclms_pkg::DEPTH];
  logic [dclms_pkg::COLOR_W-1:0] upper_rd_q;
  logic [dclms_pkg::COLOR_W-1:0] lower_rd_q;

  // Upper bank: write, then registered read.
  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.both || !wr_i.lower)) begin
      upper_mem[wr_i.addr] <= wr_i.color;
    end
    if (rd_en_i) begin
      upper_rd_q <= upper_mem[rd_addr_i];
    end
  end

  // Lower bank: same shape.
  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.both || wr_i.lower)) begin
      lower_mem[wr_i.addr] <= wr_i.color;
    end
    if (rd_en_i) begin
      lower_rd_q <= lower_mem[rd_addr_i];
    end
  end

  assign rd_data_o.upper = upper_rd_q;
  assign rd_data_o.lower = lower_rd_q;

endmodule

@@ rtl/core/dclms_scan_ctrl.sv @@
// Request sequencer: pixel writes, clearing pass, and the row-pair scan with
// its read stage and output register.
module dclms_scan_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Request side
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     in_func_i,
  input  logic [dclms_pkg::COL_W-1:0]    in_x_i,
  input  logic [dclms_pkg::Y_W-1:0]      in_y_i,
  input  logic [dclms_pkg::COLOR_W-1:0]  in_color_i,
  // Frame store
  output dclms_pkg::mem_wr_t             mem_wr_o,
  output logic                           mem_rd_en_o,
  output logic [dclms_pkg::ADDR_W-1:0]   mem_rd_addr_o,
  input  dclms_pkg::pix_pair_t           mem_rd_data_i,
  // Result side
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output dclms_pkg::pix_pair_t           out_pix_o,
  output logic [dclms_pkg::COL_W-1:0]    out_column_o,
  output logic [dclms_pkg::ROW_W-1:0]    out_row_o,
  output logic                           out_last_o
);

  localparam logic [dclms_pkg::COL_W-1:0]  LastCol = dclms_pkg::COL_W'(dclms_pkg::COLUMNS - 1);
  localparam logic [dclms_pkg::ROW_W-1:0]  LastRow = dclms_pkg::ROW_W'(dclms_pkg::HALF_ROWS - 1);
  localparam logic [dclms_pkg::ADDR_W-1:0] LastAddr = dclms_pkg::ADDR_W'(dclms_pkg::DEPTH - 1);

  dclms_pkg::state_e               state_q, state_d;
  logic [dclms_pkg::ADDR_W-1:0]    clr_addr_q, clr_addr_d;
  logic [dclms_pkg::ROW_W-1:0]     row_q, row_d;
  logic [dclms_pkg::COL_W-1:0]     nxt_col_q, nxt_col_d;
  logic                            issue_done_q, issue_done_d;
  logic                            s1_valid_q, s1_valid_d;
  logic [dclms_pkg::COL_W-1:0]     s1_col_q, s1_col_d;
  logic                            out_valid_q, out_valid_d;
  dclms_pkg::pix_pair_t            out_pix_q;
  logic [dclms_pkg::COL_W-1:0]     out_col_q;
  logic [dclms_pkg::ROW_W-1:0]     out_row_q;
  logic                            out_last_q;

  logic                            accept;
  logic                            load_out;
  logic                            wr_in_range;
  logic                            wr_lower;
  logic [dclms_pkg::Y_W-1:0]       wr_row_full;

  assign in_ready_o = (state_q == dclms_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // The read stage moves into the output register when that register is free or its beat is taken.
  assign load_out = s1_valid_q && (!out_valid_q || out_ready_i);

  // Pixel write address: pick the half bank and the row within it.
  assign wr_in_range = ({1'b0, in_x_i} < (dclms_pkg::COL_W + 1)'(dclms_pkg::COLUMNS)) &&
                       ({1'b0, in_y_i} < (dclms_pkg::Y_W + 1)'(2 * dclms_pkg::HALF_ROWS));
  assign wr_lower    = (in_y_i >= dclms_pkg::Y_W'(dclms_pkg::HALF_ROWS));
  assign wr_row_full = wr_lower ? (in_y_i - dclms_pkg::Y_W'(dclms_pkg::HALF_ROWS)) : in_y_i;

  // Sequencer next state and frame store accesses.
  always_comb begin
    state_d       = state_q;
    clr_addr_d    = clr_addr_q;
    row_d         = row_q;
    nxt_col_d     = nxt_col_q;
    issue_done_d  = issue_done_q;
    s1_valid_d    = s1_valid_q;
    s1_col_d      = s1_col_q;
    mem_wr_o      = '0;
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = {row_q, nxt_col_q};

    unique case (state_q)
      dclms_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (dclms_pkg::func_e'(in_func_i))
            dclms_pkg::FUNC_WRITE: begin
              mem_wr_o.en    = wr_in_range;
              mem_wr_o.lower = wr_lower;
              mem_wr_o.addr  = {wr_row_full[dclms_pkg::ROW_W-1:0], in_x_i};
              mem_wr_o.color = in_color_i;
            end
            dclms_pkg::FUNC_CLEAR: begin
              state_d    = dclms_pkg::ST_CLEAR;
              clr_addr_d = '0;
            end
            dclms_pkg::FUNC_SCAN: begin
              state_d      = dclms_pkg::ST_SCAN;
              nxt_col_d    = '0;
              issue_done_d = 1'b0;
              s1_valid_d   = 1'b0;
            end
            default: ;
          endcase
        end
      end

      dclms_pkg::ST_CLEAR: begin
        // Zero one address of both banks per cycle.
        mem_wr_o.en   = 1'b1;
        mem_wr_o.both = 1'b1;
        mem_wr_o.addr = clr_addr_q;
        clr_addr_d    = clr_addr_q + dclms_pkg::ADDR_W'(1);
        if (clr_addr_q == LastAddr) begin
          state_d = dclms_pkg::ST_IDLE;
        end
      end

      dclms_pkg::ST_SCAN: begin
        // A stalled read stage keeps its data: the memory holds its output.
        if (s1_valid_q && !load_out) begin
          s1_valid_d = 1'b1;
        end else if (!issue_done_q) begin
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = {row_q, nxt_col_q};
          s1_valid_d    = 1'b1;
          s1_col_d      = nxt_col_q;
          if (nxt_col_q == LastCol) begin
            issue_done_d = 1'b1;
          end else begin
            nxt_col_d = nxt_col_q + dclms_pkg::COL_W'(1);
          end
        end else begin
          s1_valid_d = 1'b0;
        end
        // The final column has left the read stage: advance the row pair.
        if (load_out && (s1_col_q == LastCol)) begin
          state_d = dclms_pkg::ST_IDLE;
          row_d   = (row_q == LastRow) ? '0 : row_q + dclms_pkg::ROW_W'(1);
        end
      end

      default: begin
        state_d = dclms_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register handshake.
  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state; reset starts a clearing pass over the frame store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= dclms_pkg::ST_CLEAR;
      clr_addr_q   <= '0;
      row_q        <= '0;
      nxt_col_q    <= '0;
      issue_done_q <= 1'b0;
      s1_valid_q   <= 1'b0;
      s1_col_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_addr_q   <= clr_addr_d;
      row_q        <= row_d;
      nxt_col_q    <= nxt_col_d;
      issue_done_q <= issue_done_d;
      s1_valid_q   <= s1_valid_d;
      s1_col_q     <= s1_col_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_pix_q  <= mem_rd_data_i;
      out_col_q  <= s1_col_q;
      out_row_q  <= row_q;
      out_last_q <= (s1_col_q == LastCol);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_pix_o    = out_pix_q;
  assign out_column_o = out_col_q;
  assign out_row_o    = out_row_q;
  assign out_last_o   = out_last_q;

endmodule

@@ rtl/core/dual_color_led_matrix_scanner_core.sv @@
// Channel   Direction  Payload
// s_axis    in         tuser: request kind; tdata: x, y, colour
// m_axis    out        tdata: pixel bits, column, row address; tlast: latch strobe
//
// A pixel write goes to the store as it is accepted; unused request kinds are ignored.
// A scan sends all columns of one row pair, one column per cycle while m_axis does not stall,
// through the single read port of the frame store.
// A clear, and the start after reset, run a clearing pass over the whole store, one
// store address (both halves) per cycle, with s_axis_tready_o low.
// A stalled m_axis holds the scan in place; no column is lost or repeated.
module dual_color_led_matrix_scanner_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] func
  input  logic [15:0] s_axis_tdata_i,   // [5:0] x, [10:6] y, [12:11] color, [15:13] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [0] upper_red, [1] upper_green, [2] lower_red,
                                        // [3] lower_green, [9:4] column,
                                        // [13:10] row_address, [15:14] zero
  output logic        m_axis_tlast_o    // last
);

  dclms_pkg::mem_wr_t              mem_wr;
  logic                            mem_rd_en;
  logic [dclms_pkg::ADDR_W-1:0]    mem_rd_addr;
  dclms_pkg::pix_pair_t            mem_rd_data;
  dclms_pkg::pix_pair_t            out_pix;
  logic [dclms_pkg::COL_W-1:0]     out_column;
  logic [dclms_pkg::ROW_W-1:0]     out_row;

  // Request sequencing and scan output.
  dclms_scan_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_func_i     (s_axis_tuser_i),
    .in_x_i        (s_axis_tdata_i[5:0]),
    .in_y_i        (s_axis_tdata_i[10:6]),
    .in_color_i    (s_axis_tdata_i[12:11]),
    .mem_wr_o      (mem_wr),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_pix_o     (out_pix),
    .out_column_o  (out_column),
    .out_row_o     (out_row),
    .out_last_o    (m_axis_tlast_o)
  );

  // Frame store.
  dclms_frame_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  // Pack the result fields; colour bit 1 is red, bit 0 is green.
  assign m_axis_tdata_o = {2'b00, out_row, out_column,
                           out_pix.lower[0], out_pix.lower[1],
                           out_pix.upper[0], out_pix.upper[1]};

endmodule

@@ bench/dual_color_led_matrix_scanner_core_test.sv @@
`timescale 1ns / 100ps

module dual_color_led_matrix_scanner_core_test;

  // The request kind the block must ignore.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned FRAME_ROWS = 2 * dclms_pkg::HALF_ROWS;
  // Covers a clearing pass issued by the final request, plus the read latency.
  localparam int unsigned DRAIN_CYCLES = 1100;
  localparam int unsigned HOLD_CYCLES = 400;

  // One column as the scanner shifts it out.
  typedef struct {
    logic       upper_red;
    logic       upper_green;
    logic       lower_red;
    logic       lower_green;
    logic [5:0] column;
    logic [3:0] row_address;
    logic       last;
  } column_beat_t;

  // Mirrors the frame store and row counter, and checks every shifted column.
  class column_predictor;
    logic [1:0]   pixel [FRAME_ROWS][dclms_pkg::COLUMNS];
    logic [3:0]   scan_row;
    column_beat_t pending_columns [$];
    int unsigned  mismatches;
    int unsigned  columns_seen;
    int unsigned  writes, clears, scans, unused;

    function void power_up();
      foreach (pixel[r, c]) pixel[r][c] = 2'b00;
      scan_row = '0;
    endfunction

    // Updates the mirror for one accepted request and queues any columns it causes.
    function void note_request(logic [1:0] kind, logic [5:0] x, logic [4:0] y,
                               logic [1:0] color);
      column_beat_t beat;
      case (kind)
        dclms_pkg::FUNC_WRITE: begin
          writes++;
          if (x < dclms_pkg::COLUMNS && y < FRAME_ROWS) pixel[y][x] = color;
        end
        dclms_pkg::FUNC_CLEAR: begin
          clears++;
          foreach (pixel[r, c]) pixel[r][c] = 2'b00;
        end
        dclms_pkg::FUNC_SCAN: begin
          scans++;
          for (int c = 0; c < dclms_pkg::COLUMNS; c++) begin
            beat.upper_red   = pixel[scan_row][c][1];
            beat.upper_green = pixel[scan_row][c][0];
            beat.lower_red   = pixel[scan_row + dclms_pkg::HALF_ROWS][c][1];
            beat.lower_green = pixel[scan_row + dclms_pkg::HALF_ROWS][c][0];
            beat.column      = c[5:0];
            beat.row_address = scan_row;
            beat.last        = (c == dclms_pkg::COLUMNS - 1);
            pending_columns.push_back(beat);
          end
          scan_row = 4'((scan_row + 1) % dclms_pkg::HALF_ROWS);
        end
        default: unused++;
      endcase
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // Compares one accepted output beat with the oldest queued column.
    function void check_column(logic [15:0] data, logic last);
      column_beat_t want;
      columns_seen++;
      if (pending_columns.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected column, expected none, actual data %h last %b",
                 $time, data, last);
        return;
      end
      want = pending_columns.pop_front();
      compare_field("upper_red", want.upper_red, data[0]);
      compare_field("upper_green", want.upper_green, data[1]);
      compare_field("lower_red", want.lower_red, data[2]);
      compare_field("lower_green", want.lower_green, data[3]);
      compare_field("column", want.column, data[9:4]);
      compare_field("row_address", want.row_address, data[13:10]);
      compare_field("last", want.last, last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic [1:0]  s_user = FUNC_UNUSED;
  logic [15:0] s_data = '0;
  logic        m_ready = 1'b0;
  wire         s_ready;
  wire         m_valid;
  wire  [15:0] m_data;
  wire         m_last;

  // Pacing controls shared between the stimulus and the receiver.
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit rx_hold = 1'b0;
  bit hold_request = 1'b0;

  column_predictor panel = new;

  dual_color_led_matrix_scanner_core DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tuser_i  (s_user),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  always #1 clk = ~clk;

  // Offers one request after a random gap, or none in steady mode, and waits until it is taken.
  task automatic offer_request(logic [1:0] kind, logic [5:0] x, logic [4:0] y,
                               logic [1:0] color);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= kind;
    s_data  <= {3'b000, color, y, x};
    do @(posedge clk); while (!s_ready);
    panel.note_request(kind, x, y, color);
  endtask

  task automatic offer_write(logic [5:0] x, logic [4:0] y, logic [1:0] color);
    offer_request(dclms_pkg::FUNC_WRITE, x, y, color);
  endtask

  // Receiver: random back-pressure, with an optional long hold.
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      gap = rx_steady ? 0 : $urandom_range(0, 16);
      if (gap > 0 || rx_hold) begin
        m_ready <= 1'b0;
        do @(posedge clk); while (--gap > 0 || rx_hold);
      end
      m_ready <= 1'b1;
      do @(posedge clk); while (!m_valid);
      panel.check_column(m_data, m_last);
    end
  end

  // Holds the output off for a long stretch once the stimulus asks for it.
  initial begin
    wait (hold_request);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Stimulus.
  initial begin
    int unsigned pick;
    logic [4:0]  y;
    panel.power_up();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a dark scan, then pixels at the edges of both halves.
    offer_request(dclms_pkg::FUNC_SCAN, 6'd0, 5'd0, 2'd0);
    offer_write(6'd0, 5'd1, 2'd3);
    offer_write(6'd63, 5'd17, 2'd3);
    offer_write(6'd42, 5'd1, 2'd1);
    offer_write(6'd21, 5'd17, 2'd2);
    offer_write(6'd63, 5'd1, 2'd2);
    offer_write(6'd0, 5'd17, 2'd1);
    offer_request(dclms_pkg::FUNC_SCAN, 6'd0, 5'd0, 2'd0);
    // Extreme rows and alternating bit patterns, then an unused kind with
    // every field bit set.
    offer_write(6'd63, 5'd31, 2'd3);
    offer_write(6'd0, 5'd0, 2'd3);
    offer_write(6'd42, 5'd21, 2'd1);
    offer_write(6'd21, 5'd10, 2'd2);
    offer_request(FUNC_UNUSED, 6'd63, 5'd31, 2'd3);
    // Scan with junk in the ignored fields.
    offer_request(dclms_pkg::FUNC_SCAN, 6'd63, 5'd31, 2'd3);
    // A clear wipes pixels written just before it.
    offer_write(6'd7, 5'd3, 2'd3);
    offer_write(6'd7, 5'd19, 2'd3);
    offer_request(dclms_pkg::FUNC_CLEAR, 6'd63, 5'd31, 2'd3);
    offer_request(dclms_pkg::FUNC_SCAN, 6'd0, 5'd0, 2'd0);
    // A later write to the same pixel wins.
    offer_write(6'd7, 5'd4, 2'd3);
    offer_write(6'd7, 5'd4, 2'd0);
    offer_write(6'd8, 5'd20, 2'd2);
    offer_write(6'd8, 5'd20, 2'd1);
    offer_request(dclms_pkg::FUNC_SCAN, 6'd0, 5'd0, 2'd0);

    // Back-pressure: hold the output while scans keep arriving.
    hold_request = 1'b1;
    tx_steady = 1'b1;
    repeat (6) offer_request(dclms_pkg::FUNC_SCAN, 6'($urandom), 5'($urandom), 2'($urandom));

    // Random: mostly writes, half of them aimed at the next row pair, so scans show lit pixels.
    for (int i = 0; i < 90; i++) begin
      if (i % 15 == 0) begin
        tx_steady = ($urandom_range(0, 2) == 0);
        rx_steady = ($urandom_range(0, 2) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if ($urandom_range(0, 1) == 1)
          y = 5'(panel.scan_row + ($urandom_range(0, 1) * dclms_pkg::HALF_ROWS));
        else
          y = 5'($urandom);
        offer_write(6'($urandom), y, 2'($urandom));
      end else if (pick < 85) begin
        offer_request(dclms_pkg::FUNC_SCAN, 6'($urandom), 5'($urandom), 2'($urandom));
      end else if (pick < 89) begin
        offer_request(dclms_pkg::FUNC_CLEAR, 6'($urandom), 5'($urandom), 2'($urandom));
      end else begin
        offer_request(FUNC_UNUSED, 6'($urandom), 5'($urandom), 2'($urandom));
      end
    end
    s_valid <= 1'b0;

    while (panel.pending_columns.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d pixel writes, %0d clears, %0d row-pair scans and %0d unused",
             panel.writes, panel.clears, panel.scans, panel.unused);
    $display("requests, with %0d columns checked under random and held back-pressure.",
             panel.columns_seen);
    if (panel.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("Timed out with %0d columns outstanding.", panel.pending_columns.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/dclms_pkg.sv
rtl/core/dclms_frame_mem.sv
rtl/core/dclms_scan_ctrl.sv
rtl/core/dual_color_led_matrix_scanner_core.sv
bench/dual_color_led_matrix_scanner_core_test.sv
